[hdl/ihg_pkg.sv]
`default_nettype none
package ihg_pkg;

  localparam int unsigned HdrBytes = 20;
  localparam int unsigned CntW     = $clog2(HdrBytes);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [CfgDataW-1:0] VersionRst  = 4'd4;
  localparam logic [CfgDataW-1:0] HdrWordsRst = 4'd5;

  // header byte positions
  localparam logic [CntW-1:0] LastPos = CntW'(HdrBytes - 1);
  localparam int unsigned     CksHiPos = 10;
  localparam int unsigned     CksLoPos = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IP_VERSION   = 1'b0,
    CFG_HEADER_WORDS = 1'b1
  } cfg_idx_e;

  // byte 0 sits at index 0
  typedef logic [HdrBytes-1:0][7:0] hdr_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } q_hs_t;

endpackage
`default_nettype wire

[hdl/ihg_intf.sv]
`default_nettype none
interface ihg_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  type_of_service;
  logic [15:0] total_length;
  logic [15:0] identification;
  logic [2:0]  frag_flags;
  logic [12:0] fragment_offset;
  logic [7:0]  time_to_live;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  modport source (
    output valid, type_of_service, total_length, identification, frag_flags,
           fragment_offset, time_to_live, protocol_number, source_address,
           destination_address,
    input  ready
  );
  modport sink (
    input  valid, type_of_service, total_length, identification, frag_flags,
           fragment_offset, time_to_live, protocol_number, source_address,
           destination_address,
    output ready
  );
endinterface

interface ihg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       last_byte;

  modport source (output valid, header_byte, last_byte, input ready);
  modport sink (input valid, header_byte, last_byte, output ready);
endinterface
`default_nettype wire

[hdl/ihg_front.sv]
`default_nettype none
module ihg_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [ihg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ihg_pkg::CfgDataW-1:0] cfg_data_i,
  ihg_in_if.sink             in_i,
  output ihg_pkg::q_hs_t     push_o,
  input  wire logic          push_ready_i,
  output ihg_pkg::hdr_t      push_data_o
);
  import ihg_pkg::*;

  logic [CfgDataW-1:0] version_q, words_q;
  logic                valid_q, valid_d;
  hdr_t                hdr_q, hdr_new;
  logic [18:0]         psum_a_q, psum_b_q, psum_a_d, psum_b_d;
  logic [19:0]         sum;
  logic [16:0]         fold1;
  logic [15:0]         fold2;
  logic [15:0]         cks;
  logic                take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VersionRst;
      words_q   <= HdrWordsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IP_VERSION:   version_q <= cfg_data_i;
        CFG_HEADER_WORDS: words_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_new     = '0;
    hdr_new[0]  = {version_q, words_q};
    hdr_new[1]  = in_i.type_of_service;
    hdr_new[2]  = in_i.total_length[15:8];
    hdr_new[3]  = in_i.total_length[7:0];
    hdr_new[4]  = in_i.identification[15:8];
    hdr_new[5]  = in_i.identification[7:0];
    hdr_new[6]  = {in_i.frag_flags, in_i.fragment_offset[12:8]};
    hdr_new[7]  = in_i.fragment_offset[7:0];
    hdr_new[8]  = in_i.time_to_live;
    hdr_new[9]  = in_i.protocol_number;
    hdr_new[12] = in_i.source_address[31:24];
    hdr_new[13] = in_i.source_address[23:16];
    hdr_new[14] = in_i.source_address[15:8];
    hdr_new[15] = in_i.source_address[7:0];
    hdr_new[16] = in_i.destination_address[31:24];
    hdr_new[17] = in_i.destination_address[23:16];
    hdr_new[18] = in_i.destination_address[15:8];
    hdr_new[19] = in_i.destination_address[7:0];
  end

  // split the word sum in two halves of five words each
  always_comb begin
    psum_a_d = '0;
    psum_b_d = '0;
    for (int i = 0; i < 5; i++) begin
      psum_a_d = psum_a_d + 19'({hdr_new[2*i], hdr_new[2*i+1]});
      psum_b_d = psum_b_d + 19'({hdr_new[10+2*i], hdr_new[11+2*i]});
    end
  end

  assign take     = in_i.valid && in_i.ready;
  assign in_i.ready = !valid_q || push_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hdr_q    <= hdr_new;
      psum_a_q <= psum_a_d;
      psum_b_q <= psum_b_d;
    end
  end

  // fold carries twice, then complement
  assign sum   = 20'(psum_a_q) + 20'(psum_b_q);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign cks   = ~fold2;

  always_comb begin
    push_data_o           = hdr_q;
    push_data_o[CksHiPos] = cks[15:8];
    push_data_o[CksLoPos] = cks[7:0];
  end

  assign push_o.valid = valid_q;
  assign push_o.ready = push_ready_i;

endmodule
`default_nettype wire

[hdl/ihg_queue.sv]
`default_nettype none
module ihg_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  ihg_pkg::q_hs_t      push_i,
  output logic                push_ready_o,
  input  ihg_pkg::hdr_t       push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output ihg_pkg::hdr_t       pop_data_o
);
  import ihg_pkg::*;

  hdr_t               mem_q [QDepth];
  logic [QPtrW-1:0]   wr_q, rd_q;
  logic [QPtrW:0]     cnt_q, cnt_d;
  logic               wr, rd;

  assign push_ready_o = (cnt_q != (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign wr = push_i.valid && push_ready_o;
  assign rd = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_q <= wr_q + 1'b1;
      end
      if (rd) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[hdl/ihg_back.sv]
`default_nettype none
module ihg_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         pop_valid_i,
  output logic              pop_ready_o,
  input  ihg_pkg::hdr_t     pop_data_i,
  ihg_out_if.source         out_o
);
  import ihg_pkg::*;

  logic [CntW-1:0] pos_q, pos_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            load, at_last;

  assign load    = pop_valid_i && (!valid_q || out_o.ready);
  assign at_last = (pos_q == LastPos);
  // release the queue entry with its final byte
  assign pop_ready_o = load && at_last;

  always_comb begin
    pos_d = pos_q;
    if (load) begin
      pos_d = at_last ? '0 : pos_q + 1'b1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= pop_data_i[pos_q];
      last_q <= at_last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.header_byte = byte_q;
  assign out_o.last_byte   = last_q;

endmodule
`default_nettype wire

[hdl/ipv4_header_generator.sv]
// Channel   Dir  Width  Contents
// in_i      in   136    per-packet IPv4 fields, one header request per item
// out_o     out  9      header_byte (8) and last_byte, 20 items per request
// cfg       in   1+4    ip_version (index 0), header_words (index 1)
//
// Each request yields 20 bytes, one per cycle while out_o is ready; the byte
// serializer bounds the request rate. With the queue empty, the first byte
// goes through the capture stage, a queue entry and the byte register. Up to
// four requests are held (capture stage, a two-entry queue and the one whose
// final byte waits on out_o). Reset is asynchronous, active low; a stall on
// out_o holds the current byte and backs up into the queue and in_i.
`default_nettype none
module ipv4_header_generator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [ihg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ihg_pkg::CfgDataW-1:0] cfg_data_i,
  ihg_in_if.sink    in_i,
  ihg_out_if.source out_o
);
  import ihg_pkg::*;

  q_hs_t push;
  logic  push_ready;
  hdr_t  push_data;
  logic  pop_valid, pop_ready;
  hdr_t  pop_data;

  ihg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ihg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ihg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

[hdl/ihg_checker.sv]
`default_nettype none
module ihg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);
  import ihg_pkg::*;

  logic [CntW-1:0] pos_q;
  logic [2:0]      open_q;
  logic            in_acc, out_acc, done;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign done    = out_acc && out_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      open_q <= '0;
    end else begin
      if (out_acc) begin
        pos_q <= (pos_q == LastPos) ? '0 : pos_q + 1'b1;
      end
      open_q <= open_q + 3'(in_acc) - 3'(done);
    end
  end

  // stalled byte holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled output byte changed");

  // last flag sits exactly on the twentieth byte
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (pos_q == LastPos)))
    else $error("last_byte out of place");

  // no bytes without a pending request
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != '0)
    else $error("output without request");

  // never more requests held than capture stage, queue and the one draining
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 3'(QDepth + 2))
    else $error("too many requests in flight");

endmodule

bind ipv4_header_generator ihg_checker u_ihg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.header_byte),
  .out_last_i  (out_o.last_byte)
);
`default_nettype wire
